@@ design/acbd_pkg.sv @@
package acbd_pkg;

  localparam int MaxPeople = 10;
  localparam int ItemCount = 40;

  localparam int KindW   = 2;
  localparam int PersonW = 4;
  localparam int HatW    = 40;
  localparam int WaysW   = 30;
  localparam int CfgW    = 4;

  localparam logic [WaysW-1:0] Modulus = 30'd1000000007;

  typedef enum logic [KindW-1:0] {
    KindClear   = 2'd0,
    KindLoad    = 2'd1,
    KindCompute = 2'd2
  } kind_e;

  function automatic logic [WaysW-1:0] add_mod(input logic [WaysW-1:0] a,
                                               input logic [WaysW-1:0] b);
    logic [WaysW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, Modulus}) begin
      s = s - {1'b0, Modulus};
    end
    return s[WaysW-1:0];
  endfunction

endpackage

@@ design/acbd_count_mem.sv @@
module acbd_count_mem #(
  parameter int AddrW = 10,
  parameter int DataW = 30
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  localparam int Depth = 1 << AddrW;

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/acbd_owner_map.sv @@
module acbd_owner_map
  import acbd_pkg::*;
#(
  parameter int MAX_PEOPLE = MaxPeople,
  parameter int ITEM_COUNT = ItemCount,
  parameter int ItemW      = (ITEM_COUNT > 1) ? $clog2(ITEM_COUNT) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  clear_i,
  input  logic                  load_i,
  input  logic [PersonW-1:0]    person_i,
  input  logic [HatW-1:0]       hat_set_i,
  input  logic [MAX_PEOPLE-1:0] full_i,
  input  logic [ItemW-1:0]      item_i,
  output logic [MAX_PEOPLE-1:0] owners_o
);

  logic [ITEM_COUNT-1:0] hat_ext;
  logic [ITEM_COUNT-1:0] row_q [MAX_PEOPLE];

  for (genvar j = 0; j < ITEM_COUNT; j++) begin : g_ext
    if (j < HatW) begin : g_bit
      assign hat_ext[j] = hat_set_i[j];
    end else begin : g_zero
      assign hat_ext[j] = 1'b0;
    end
  end

  for (genvar r = 0; r < MAX_PEOPLE; r++) begin : g_row
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        row_q[r] <= '0;
      end else if (clear_i) begin
        row_q[r] <= '0;
      end else if (load_i && (person_i == PersonW'(r))) begin
        row_q[r] <= row_q[r] | hat_ext;
      end
    end

    assign owners_o[r] = row_q[r][item_i] & full_i[r];
  end

endmodule

@@ design/assignment_count_bitmask_dp_unit.sv @@
// Channel  | Direction | Handshake                 | Payload
// command  | in        | start / busy              | kind_i, person_i, hat_set_i
// result   | out       | ways_valid_o (strobe)     | ways_o
// config   | in        | cfg_valid_i / cfg_ready_o | cfg_data_i (person_count)
//
// Clear and load are taken while idle and leave busy low.
// Compute holds busy while it zeroes the count table (entry 0 set to 1), then, per item
// with owners, walks the masks downwards, skips masks whose count is zero and adds each
// other count into every mask that it can hand the item to; the strobe follows.
// Reset (rst_ni low, asynchronous) empties the owner map and sets person_count to 1.
// The result strobe lasts one cycle and cannot be stalled.
module assignment_count_bitmask_dp_unit
  import acbd_pkg::*;
#(
  parameter int MAX_PEOPLE = MaxPeople,
  parameter int ITEM_COUNT = ItemCount
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [KindW-1:0]   kind_i,
  input  logic [PersonW-1:0] person_i,
  input  logic [HatW-1:0]    hat_set_i,
  output logic               ways_valid_o,
  output logic [WaysW-1:0]   ways_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgW-1:0]    cfg_data_i
);

  localparam int MaskW = MAX_PEOPLE;
  localparam int ItemW = (ITEM_COUNT > 1) ? $clog2(ITEM_COUNT) : 1;
  localparam int PIdxW = $clog2(MAX_PEOPLE + 1);
  localparam int PSelW = (MAX_PEOPLE > 1) ? $clog2(MAX_PEOPLE) : 1;

  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StInit  = 9'b000000010,
    StItem  = 9'b000000100,
    StRdCur = 9'b000001000,
    StCur   = 9'b000010000,
    StPStep = 9'b000100000,
    StWr    = 9'b001000000,
    StFinRd = 9'b010000000,
    StFin   = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic [CfgW-1:0]  pc_q;
  logic [ItemW-1:0] item_q, item_d;
  logic [MaskW-1:0] mask_q, mask_d;
  logic [PIdxW-1:0] p_q, p_d;
  logic [WaysW-1:0] cur_q, cur_d;
  logic [MaskW-1:0] taddr_q, taddr_d;
  logic [WaysW-1:0] ways_q, ways_d;
  logic             ways_valid_q, ways_valid_d;

  logic [PIdxW-1:0] n_cnt;
  logic [MaskW-1:0] full_mask;
  logic [MaskW-1:0] owners;
  logic [PSelW-1:0] p_sel;
  logic [MaskW-1:0] p_bit;
  logic [MaskW-1:0] tgt;
  logic             eligible;
  logic             item_last;
  logic             adv_mask, adv_item;
  logic             accept;
  logic             map_clear, map_load;

  logic             mem_we, mem_re;
  logic [MaskW-1:0] mem_waddr, mem_raddr;
  logic [WaysW-1:0] mem_wdata, mem_rdata;

  assign n_cnt = (pc_q > CfgW'(MAX_PEOPLE)) ? PIdxW'(MAX_PEOPLE) : PIdxW'(pc_q);

  always_comb begin
    for (int i = 0; i < MaskW; i++) begin
      full_mask[i] = (i < int'(n_cnt));
    end
  end

  assign busy        = (state_q != StIdle);
  assign cfg_ready_o = ~busy;
  assign accept      = start & ~busy;
  assign map_clear   = accept && (kind_i == KindClear);
  assign map_load    = accept && (kind_i == KindLoad);

  assign p_sel     = p_q[PSelW-1:0];
  assign p_bit     = MaskW'(1) << p_sel;
  assign tgt       = mask_q | p_bit;
  assign eligible  = owners[p_sel] & ~mask_q[p_sel];
  assign item_last = (item_q == ItemW'(ITEM_COUNT - 1));

  acbd_owner_map #(
    .MAX_PEOPLE(MAX_PEOPLE),
    .ITEM_COUNT(ITEM_COUNT),
    .ItemW     (ItemW)
  ) u_owner_map (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (map_clear),
    .load_i   (map_load),
    .person_i (person_i),
    .hat_set_i(hat_set_i),
    .full_i   (full_mask),
    .item_i   (item_q),
    .owners_o (owners)
  );

  acbd_count_mem #(
    .AddrW(MaskW),
    .DataW(WaysW)
  ) u_count_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    mask_d       = mask_q;
    p_d          = p_q;
    cur_d        = cur_q;
    taddr_d      = taddr_q;
    ways_d       = ways_q;
    ways_valid_d = 1'b0;
    adv_mask     = 1'b0;
    adv_item     = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = mask_q;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = mask_q;

    unique case (state_q)
      StIdle: begin
        if (accept && (kind_i == KindCompute)) begin
          mask_d  = '0;
          state_d = StInit;
        end
      end
      StInit: begin
        mem_we    = 1'b1;
        mem_waddr = mask_q;
        mem_wdata = (mask_q == '0) ? WaysW'(1) : '0;
        if (mask_q == full_mask) begin
          item_d  = '0;
          state_d = StItem;
        end else begin
          mask_d = mask_q + MaskW'(1);
        end
      end
      StItem: begin
        if (owners != '0) begin
          mask_d  = full_mask;
          state_d = StRdCur;
        end else begin
          adv_item = 1'b1;
        end
      end
      StRdCur: begin
        mem_re    = 1'b1;
        mem_raddr = mask_q;
        state_d   = StCur;
      end
      StCur: begin
        if (mem_rdata == '0) begin
          adv_mask = 1'b1;
        end else begin
          cur_d   = mem_rdata;
          p_d     = '0;
          state_d = StPStep;
        end
      end
      StPStep: begin
        if (p_q == n_cnt) begin
          adv_mask = 1'b1;
        end else if (eligible) begin
          mem_re    = 1'b1;
          mem_raddr = tgt;
          taddr_d   = tgt;
          state_d   = StWr;
        end else begin
          p_d = p_q + PIdxW'(1);
        end
      end
      StWr: begin
        mem_we    = 1'b1;
        mem_waddr = taddr_q;
        mem_wdata = add_mod(mem_rdata, cur_q);
        p_d       = p_q + PIdxW'(1);
        state_d   = StPStep;
      end
      StFinRd: begin
        mem_re    = 1'b1;
        mem_raddr = full_mask;
        state_d   = StFin;
      end
      StFin: begin
        ways_d       = mem_rdata;
        ways_valid_d = 1'b1;
        state_d      = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    priority if (adv_mask && (mask_q != '0)) begin
      mask_d  = mask_q - MaskW'(1);
      state_d = StRdCur;
    end else if (adv_mask || adv_item) begin
      if (item_last) begin
        state_d = StFinRd;
      end else begin
        item_d  = item_q + ItemW'(1);
        state_d = StItem;
      end
    end else begin
      // hold
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      ways_valid_q <= 1'b0;
      pc_q         <= CfgW'(1);
    end else begin
      state_q      <= state_d;
      ways_valid_q <= ways_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        pc_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    mask_q  <= mask_d;
    p_q     <= p_d;
    cur_q   <= cur_d;
    taddr_q <= taddr_d;
    ways_q  <= ways_d;
  end

  assign ways_valid_o = ways_valid_q;
  assign ways_o       = ways_q;

`ifndef NO_ASSERTIONS
  a_ways_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ways_valid_o |-> (ways_o < Modulus))
    else $error("ways beat not reduced modulo the prime");

  a_result_after_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ways_valid_o |-> !$past(busy) || (state_q == StIdle))
    else $error("ways beat while the walk is still running");

  a_single_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("count memory read and written in one cycle");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ways_valid_o |=> !ways_valid_o)
    else $error("ways beat held for more than one cycle");
`endif

endmodule

@@ tb/sv/ways_checker.sv @@
module ways_checker
  import acbd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  logic [KindW-1:0]   kind_i,
  input  logic [PersonW-1:0] person_i,
  input  logic [HatW-1:0]    hat_set_i,
  input  logic               ways_valid_o,
  input  logic [WaysW-1:0]   ways_o,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_o,
  input  logic [CfgW-1:0]    cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 checked_o
);

  logic [MaxPeople-1:0] owner_sets [ItemCount];
  logic [CfgW-1:0]      people_cfg;
  logic [WaysW-1:0]     ways_due [$];
  logic [WaysW-1:0]     want;
  int                   fails = 0;
  int                   checked = 0;
  int                   pending_q = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending_q;
  assign checked_o    = checked;

  task automatic flag(input string what);
    $display("[ways_checker] mismatch: %s", what);
    fails++;
  endtask

  function automatic logic [WaysW-1:0] count_assignments();
    logic [WaysW-1:0] tbl [1 << MaxPeople];
    logic [WaysW:0]   sum;
    int               n;
    int               fullmask;
    int               owners;
    int               dst;
    n = (people_cfg > MaxPeople) ? MaxPeople : int'(people_cfg);
    fullmask = (1 << n) - 1;
    foreach (tbl[i]) tbl[i] = '0;
    tbl[0] = 1;
    for (int it = 0; it < ItemCount; it++) begin
      owners = int'(owner_sets[it]) & fullmask;
      if (owners != 0) begin
        // walk masks downwards so an item goes to at most one person
        for (int mk = fullmask; mk >= 0; mk--) begin
          if (tbl[mk] != 0) begin
            for (int p = 0; p < n; p++) begin
              if (owners[p] && !mk[p]) begin
                dst = mk | (1 << p);
                sum = {1'b0, tbl[dst]} + {1'b0, tbl[mk]};
                if (sum >= {1'b0, Modulus}) begin
                  sum = sum - {1'b0, Modulus};
                end
                tbl[dst] = sum[WaysW-1:0];
              end
            end
          end
        end
      end
    end
    return tbl[fullmask];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (owner_sets[j]) owner_sets[j] = '0;
      people_cfg = 1;
      ways_due.delete();
      pending_q <= 0;
    end else begin
      if (ways_valid_o) begin
        if (ways_due.size() == 0) begin
          flag($sformatf("ways %0d with no compute outstanding", ways_o));
        end else begin
          want = ways_due.pop_front();
          checked++;
          if (ways_o !== want) begin
            flag($sformatf("ways %0d, expected %0d", ways_o, want));
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        people_cfg = cfg_data_i;
      end
      if (start && !busy) begin
        case (kind_i)
          KindClear: begin
            foreach (owner_sets[j]) owner_sets[j] = '0;
          end
          KindLoad: begin
            if (person_i < MaxPeople) begin
              for (int j = 0; j < ItemCount; j++) begin
                if (hat_set_i[j]) owner_sets[j][person_i] = 1'b1;
              end
            end
          end
          KindCompute: begin
            ways_due.push_back(count_assignments());
          end
          default: begin
          end
        endcase
      end
      pending_q <= ways_due.size();
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
  import acbd_pkg::*;

  localparam logic [KindW-1:0] KindUnused = 2'd3;
  // IdleLimit stays above the slowest compute (ten people on all forty items)
  localparam int IdleLimit   = 4_000_000;
  localparam int RandomItems = 1528;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [KindW-1:0]   kind_i = '0;
  logic [PersonW-1:0] person_i = '0;
  logic [HatW-1:0]    hat_set_i = '0;
  logic               ways_valid_o;
  logic [WaysW-1:0]   ways_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgW-1:0]    cfg_data_i = '0;

  int fail_count;
  int pending;
  int checked;
  int idle_run = 0;
  int sent_load = 0;
  int sent_clear = 0;
  int sent_compute = 0;
  int sent_noise = 0;
  bit steady = 1'b0;

  assignment_count_bitmask_dp_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .kind_i      (kind_i),
    .person_i    (person_i),
    .hat_set_i   (hat_set_i),
    .ways_valid_o(ways_valid_o),
    .ways_o      (ways_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  ways_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .kind_i      (kind_i),
    .person_i    (person_i),
    .hat_set_i   (hat_set_i),
    .ways_valid_o(ways_valid_o),
    .ways_o      (ways_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || ways_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_run <= 0;
    end else if (idle_run >= IdleLimit) begin
      $display("[assignment_count_bitmask_dp_unit] ERROR");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  function automatic logic [HatW-1:0] draw_hats();
    logic [63:0]     r;
    logic [HatW-1:0] one;
    one = 1;
    case ($urandom_range(0, 7))
      0: return '1;
      1: return '0;
      2: return one << $urandom_range(0, HatW - 1);
      3, 4: begin
        r = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
        return r[HatW-1:0];
      end
      default: begin
        r = {$urandom, $urandom};
        return r[HatW-1:0];
      end
    endcase
  endfunction

  // hold start high across back-to-back beats; drop it only for a gap
  task automatic issue(input logic [KindW-1:0] k, input logic [PersonW-1:0] who,
                       input logic [HatW-1:0] hats);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start     <= 1'b1;
    kind_i    <= k;
    person_i  <= who;
    hat_set_i <= hats;
    do @(posedge clk_i); while (busy);
    case (k)
      KindClear:   sent_clear++;
      KindLoad:    sent_load++;
      KindCompute: sent_compute++;
      default:     sent_noise++;
    endcase
  endtask

  task automatic set_people(input logic [CfgW-1:0] v);
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int                 n;
    int                 items;
    int                 phase_end;
    int                 loads;
    logic [PersonW-1:0] who;
    logic [HatW-1:0]    pair;
    n = 1;
    items = 0;
    phase_end = 0;
    pair = 3;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue(KindCompute, '0, '0);
    issue(KindUnused, '1, '1);
    issue(KindLoad, 0, '1);
    issue(KindLoad, 9, '1);
    issue(KindLoad, 15, '1);
    issue(KindCompute, '1, '0);
    issue(KindClear, '0, '1);
    issue(KindCompute, '0, '0);
    set_people(0);
    issue(KindCompute, '0, '0);
    set_people(15);
    for (int p = 0; p < MaxPeople; p++) begin
      issue(KindLoad, PersonW'(p), pair << (29 + p));
    end
    issue(KindCompute, '0, '0);
    set_people(10);
    issue(KindClear, '0, '0);
    issue(KindCompute, '0, '0);

    while (items < RandomItems) begin
      if (items >= phase_end) begin
        n = $urandom_range(0, 4);
        set_people(CfgW'(n));
        phase_end = items + $urandom_range(80, 160);
      end
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1) == 1) begin
        issue(KindClear, PersonW'($urandom), draw_hats());
        items++;
      end
      loads = $urandom_range(1, 8);
      repeat (loads) begin
        if ($urandom_range(0, 19) == 0) begin
          if ($urandom_range(0, 1) == 1) begin
            issue(KindUnused, PersonW'($urandom), draw_hats());
          end else begin
            issue(KindLoad, PersonW'($urandom_range(10, 15)), draw_hats());
          end
        end else begin
          if (n == 0 || $urandom_range(0, 3) == 0) begin
            who = PersonW'($urandom_range(0, MaxPeople - 1));
          end else begin
            who = PersonW'($urandom_range(0, n - 1));
          end
          issue(KindLoad, who, draw_hats());
          items++;
        end
      end
      issue(KindCompute, PersonW'($urandom), draw_hats());
      items++;
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("Run covered %0d loads, %0d clears, %0d computes and %0d ignored commands.",
             sent_load, sent_clear, sent_compute, sent_noise);
    $display("Counts checked: %0d, with person_count at 0, 1, 10, 15 and random 0..4.",
             checked);
    if (fail_count == 0 && pending == 0) begin
      $display("[assignment_count_bitmask_dp_unit] OK");
    end else begin
      $display("[assignment_count_bitmask_dp_unit] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/acbd_pkg.sv
design/acbd_count_mem.sv
design/acbd_owner_map.sv
design/assignment_count_bitmask_dp_unit.sv
tb/sv/ways_checker.sv
tb/sv/tb_top.sv
